// ===== hdl/i2cm_pkg.sv =====
// Shared types and constants for the two-transaction I2C master.
`default_nettype none
package i2cm_pkg;

    localparam int unsigned PHASE_W           = 16;
    localparam logic [PHASE_W-1:0] PHASE_RST  = 16'd50;
    localparam logic [3:0] BITS_PER_BYTE      = 4'd8;
    localparam logic [1:0] BYTE_FIRST         = 2'd0;
    localparam logic [1:0] BYTE_SECOND        = 2'd1;
    localparam logic [1:0] BYTE_THIRD         = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'd0,
        ST_STA_A  = 5'd1,
        ST_STA_B  = 5'd2,
        ST_TX_LO  = 5'd3,
        ST_TX_HI  = 5'd4,
        ST_AKI_LO = 5'd5,
        ST_AKI_HI = 5'd6,
        ST_RX_LO  = 5'd7,
        ST_RX_HI  = 5'd8,
        ST_AKO_LO = 5'd9,
        ST_AKO_HI = 5'd10,
        ST_STP_A  = 5'd11,
        ST_STP_B  = 5'd12,
        ST_STP_C  = 5'd13
    } t_step;

    typedef struct packed {
        logic        nack_seen;
        logic [15:0] read_word;
        logic        done_res;
        logic        busy_res;
        logic        sda_drive;
        logic        sda_level;
        logic        scl_level;
    } t_result;

endpackage
`default_nettype wire

// ===== hdl/i2cm_seq.sv =====
// Bus sequencer: state registers and the per-tick next-state and pin logic.
`default_nettype none
module i2cm_seq
    import i2cm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [PHASE_W-1:0] i_phase_ticks,
    input  wire logic               i_go,
    input  wire logic               i_kind,
    input  wire logic [6:0]         i_target_address,
    input  wire logic [7:0]         i_write_byte,
    input  wire logic               i_sda_in,
    output t_result                 o_res
);

    t_step              r_step,  n_step;
    logic [PHASE_W-1:0] r_pc,    n_pc;
    logic [3:0]         r_bit,   n_bit;
    logic [1:0]         r_byte,  n_byte;
    logic [7:0]         r_shift, n_shift;
    logic [15:0]        r_recv,  n_recv;
    logic               r_kind,  n_kind;
    logic [6:0]         r_addr,  n_addr;
    logic [7:0]         r_data,  n_data;
    logic               r_nack,  n_nack;

    t_step              step_cur;
    logic [PHASE_W-1:0] pc_base;
    logic [PHASE_W-1:0] pc_inc;
    logic [PHASE_W-1:0] len;
    logic [3:0]         bit_inc;
    logic [7:0]         shift_rx;
    logic               busy;
    logic               phase_end;
    logic               done;
    logic               scl;
    logic               sda;
    logic               drv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_IDLE;
            r_pc    <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
            r_shift <= '0;
            r_recv  <= '0;
            r_kind  <= 1'b0;
            r_addr  <= '0;
            r_data  <= '0;
            r_nack  <= 1'b0;
        end else if (i_en) begin
            r_step  <= n_step;
            r_pc    <= n_pc;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
            r_shift <= n_shift;
            r_recv  <= n_recv;
            r_kind  <= n_kind;
            r_addr  <= n_addr;
            r_data  <= n_data;
            r_nack  <= n_nack;
        end
    end

    always_comb begin
        n_step  = r_step;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_shift = r_shift;
        n_recv  = r_recv;
        n_kind  = r_kind;
        n_addr  = r_addr;
        n_data  = r_data;
        n_nack  = r_nack;
        step_cur = r_step;
        pc_base  = r_pc;
        done     = 1'b0;

        // latch a new request when idle
        if (r_step == ST_IDLE && i_go) begin
            n_kind   = i_kind;
            n_addr   = i_target_address;
            n_data   = i_write_byte;
            n_nack   = 1'b0;
            pc_base  = '0;
            step_cur = ST_STA_A;
        end
        n_step = step_cur;
        busy   = (step_cur != ST_IDLE);

        scl = 1'b1;
        sda = 1'b1;
        drv = 1'b0;
        case (step_cur)
            ST_STA_A:  begin scl = 1'b1; sda = 1'b1; drv = 1'b1; end
            ST_STA_B:  begin scl = 1'b1; sda = 1'b0; drv = 1'b1; end
            ST_TX_LO:  begin scl = 1'b0; sda = r_shift[7]; drv = 1'b1; end
            ST_TX_HI:  begin scl = 1'b1; sda = r_shift[7]; drv = 1'b1; end
            ST_AKI_LO: scl = 1'b0;
            ST_AKI_HI: scl = 1'b1;
            ST_RX_LO:  scl = 1'b0;
            ST_RX_HI:  scl = 1'b1;
            ST_AKO_LO: begin scl = 1'b0; sda = (r_byte != BYTE_SECOND); drv = 1'b1; end
            ST_AKO_HI: begin scl = 1'b1; sda = (r_byte != BYTE_SECOND); drv = 1'b1; end
            ST_STP_A:  begin scl = 1'b0; sda = 1'b0; drv = 1'b1; end
            ST_STP_B:  begin scl = 1'b1; sda = 1'b0; drv = 1'b1; end
            ST_STP_C:  begin scl = 1'b1; sda = 1'b1; drv = 1'b1; end
            default: ;
        endcase

        len       = (i_phase_ticks == '0) ? {{(PHASE_W-1){1'b0}}, 1'b1} : i_phase_ticks;
        pc_inc    = pc_base + {{(PHASE_W-1){1'b0}}, 1'b1};
        phase_end = (pc_inc >= len) || (pc_inc == '0);
        bit_inc   = r_bit + 4'd1;
        shift_rx  = {r_shift[6:0], i_sda_in};

        if (!busy) begin
            n_pc = '0;
        end else if (!phase_end) begin
            n_pc = pc_inc;
        end else begin
            n_pc = '0;
            case (step_cur)
                ST_STA_A: n_step = ST_STA_B;
                ST_STA_B: begin
                    n_shift = {n_addr, n_kind};
                    n_bit   = '0;
                    n_byte  = BYTE_FIRST;
                    n_step  = ST_TX_LO;
                end
                ST_TX_LO: n_step = ST_TX_HI;
                ST_TX_HI: begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bit   = bit_inc;
                    n_step  = (bit_inc >= BITS_PER_BYTE) ? ST_AKI_LO : ST_TX_LO;
                end
                ST_AKI_LO: n_step = ST_AKI_HI;
                ST_AKI_HI: begin
                    if (i_sda_in) begin
                        n_nack = 1'b1;
                    end
                    if (r_byte == BYTE_FIRST) begin
                        n_byte = BYTE_SECOND;
                        n_bit  = '0;
                        if (n_kind) begin
                            n_shift = '0;
                            n_step  = ST_RX_LO;
                        end else begin
                            n_shift = n_data;
                            n_step  = ST_TX_LO;
                        end
                    end else begin
                        n_step = ST_STP_A;
                    end
                end
                ST_RX_LO: n_step = ST_RX_HI;
                ST_RX_HI: begin
                    n_shift = shift_rx;
                    n_bit   = bit_inc;
                    if (bit_inc >= BITS_PER_BYTE) begin
                        if (r_byte == BYTE_SECOND) begin
                            n_recv = {shift_rx, 8'h00};
                        end else begin
                            n_recv = {r_recv[15:8], shift_rx};
                        end
                        n_step = ST_AKO_LO;
                    end else begin
                        n_step = ST_RX_LO;
                    end
                end
                ST_AKO_LO: n_step = ST_AKO_HI;
                ST_AKO_HI: begin
                    if (r_byte == BYTE_SECOND) begin
                        n_byte  = BYTE_THIRD;
                        n_bit   = '0;
                        n_shift = '0;
                        n_step  = ST_RX_LO;
                    end else begin
                        n_step = ST_STP_A;
                    end
                end
                ST_STP_A: n_step = ST_STP_B;
                ST_STP_B: n_step = ST_STP_C;
                ST_STP_C: begin
                    n_step = ST_IDLE;
                    done   = 1'b1;
                end
                default: n_step = ST_IDLE;
            endcase
        end

        o_res.scl_level = scl;
        o_res.sda_level = sda;
        o_res.sda_drive = drv;
        o_res.busy_res  = busy;
        o_res.done_res  = done;
        o_res.read_word = n_recv;
        o_res.nack_seen = n_nack;
    end

endmodule
`default_nettype wire

// ===== hdl/i2cm_out.sv =====
// Output register stage holding one pin result until the sink takes it.
`default_nettype none
module i2cm_out
    import i2cm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_take,
    output logic         o_valid,
    output logic         o_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/i2c_master_two_transaction.sv =====
// Each request's pin result is registered onto m_axis in the cycle after acceptance.
// Throughput: one request per cycle; the output register takes a new result while
// the previous one drains, so s_axis_tready stays high unless m_axis stalls.
// Reset (synchronous, active low): sequencer idle, lines released, phase length 50,
// output register empty.
`default_nettype none
module i2c_master_two_transaction
    import i2cm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [PHASE_W-1:0] i_cfg_wdata,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // go[0], target_address[7:1], write_byte[15:8], sda_in[16], zero[23:17]
    input  wire logic [23:0]        s_axis_tdata,
    // kind[0]
    input  wire logic               s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
    // read_word[20:5], nack_seen[21], zero[23:22]
    output logic [23:0]             m_axis_tdata
);

    logic [PHASE_W-1:0] r_phase_ticks;
    logic               accept;
    t_result            seq_res;
    t_result            out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_RST;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    i2cm_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (accept),
        .i_phase_ticks    (r_phase_ticks),
        .i_go             (s_axis_tdata[0]),
        .i_kind           (s_axis_tuser),
        .i_target_address (s_axis_tdata[7:1]),
        .i_write_byte     (s_axis_tdata[15:8]),
        .i_sda_in         (s_axis_tdata[16]),
        .o_res            (seq_res)
    );

    i2cm_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_res   (seq_res),
        .i_take  (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_ready (s_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.nack_seen, out_res.read_word, out_res.done_res,
                           out_res.busy_res, out_res.sda_drive, out_res.sda_level,
                           out_res.scl_level};

endmodule
`default_nettype wire
